// File: hw/rtl/hrc_pkg.sv
// Shared types and constants of the hardware-monitor reading converter.
// No dependencies; every other RTL file imports this package.
package hrc_pkg;

    // Sensor kinds on the op field
    localparam logic [1:0] OP_VOLT = 2'd0;
    localparam logic [1:0] OP_TEMP = 2'd1;
    localparam logic [1:0] OP_FAN  = 2'd2;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned RAW_W     = 16;
    localparam int unsigned SCALE_W   = 18;
    localparam int unsigned AUX_W     = 8;
    localparam int unsigned COUNT_W   = 12;
    localparam int unsigned VALUE_W   = 29;
    localparam int unsigned VPROD_W   = CODE_W + SCALE_W;
    localparam int unsigned TPROD_W   = 28;

    localparam logic [CODE_W-1:0]  VOLT_BAD_HIGH  = 8'hff;
    localparam logic [CODE_W-1:0]  TEMP_LIMIT_ALT = 8'd111;
    localparam logic [CODE_W-1:0]  TEMP_LIMIT_STD = 8'd128;
    localparam logic [RAW_W-1:0]   FAN_BAD_COUNT  = 16'h0fff;
    localparam logic [TPROD_W-1:0] MICRO_PER_UNIT = 28'd1000000;
    localparam logic [VALUE_W-1:0] ZERO_C_MICROK  = 29'd273150000;
    localparam logic [VALUE_W-1:0] VALUE_MAX      = 29'd400150000;

    // Fan divider: restoring division, a few quotient bits per cycle
    localparam int unsigned DIV_BITS_PER_STEP = 6;
    localparam int unsigned DIV_STEPS         = 4;
    localparam int unsigned DIV_NUM_W         = DIV_BITS_PER_STEP * DIV_STEPS;
    localparam int unsigned DIV_STEP_W        = $clog2(DIV_STEPS);
    localparam logic [DIV_NUM_W-1:0] FAN_NUMERATOR = 24'd1500000;

    // Work queue between classifier and execution unit
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,   // invalid reading, result is all zero
        KIND_VOLT = 2'd1,
        KIND_TEMP = 2'd2,
        KIND_FAN  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [SCALE_W-1:0]  scale;
        logic [COUNT_W-1:0]  count;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// File: hw/rtl/hrc_front.sv
// Front end: holds the temperature mode register and classifies each request
// into a work entry for the queue. Depends on hrc_pkg.
module hrc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_write,
    input  logic [hrc_pkg::AUX_W-1:0] i_cfg_data,
    input  logic [1:0]                i_op,
    input  logic [hrc_pkg::RAW_W-1:0] i_raw_reading,
    input  logic [hrc_pkg::SCALE_W-1:0] i_user_scale,
    input  logic [hrc_pkg::SCALE_W-1:0] i_table_scale,
    input  logic [hrc_pkg::AUX_W-1:0] i_aux_mask,
    output hrc_pkg::t_work            o_work
);
    import hrc_pkg::*;

    logic [AUX_W-1:0]  r_temp_mode;
    logic [CODE_W-1:0] w_code;
    logic [CODE_W-1:0] w_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_mode <= '0;
        end else if (i_cfg_write) begin
            r_temp_mode <= i_cfg_data;
        end
    end

    assign w_code  = i_raw_reading[CODE_W-1:0];
    assign w_limit = ((r_temp_mode & i_aux_mask) != '0) ? TEMP_LIMIT_ALT : TEMP_LIMIT_STD;

    always_comb begin
        o_work.kind  = KIND_ZERO;
        o_work.code  = w_code;
        o_work.scale = (i_user_scale != '0) ? i_user_scale : i_table_scale;
        o_work.count = i_raw_reading[COUNT_W-1:0];
        unique case (i_op)
            OP_VOLT: begin
                if (w_code != '0 && w_code != VOLT_BAD_HIGH) begin
                    o_work.kind = KIND_VOLT;
                end
            end
            OP_TEMP: begin
                if (w_code != '0 && w_code < w_limit) begin
                    o_work.kind = KIND_TEMP;
                end
            end
            OP_FAN: begin
                // a zero count has no rpm: flag it invalid
                if (i_raw_reading != '0 && i_raw_reading < FAN_BAD_COUNT) begin
                    o_work.kind = KIND_FAN;
                end
            end
            default: begin
                o_work.kind = KIND_ZERO;
            end
        endcase
    end

endmodule

// File: hw/rtl/hrc_queue.sv
// Short work queue between the classifier and the execution unit.
// Depends on hrc_pkg.
module hrc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hrc_pkg::t_work       i_push_data,
    input  logic                 i_pop,
    output hrc_pkg::t_work       o_pop_data,
    output hrc_pkg::t_queue_stat o_stat
);
    import hrc_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: hw/rtl/hrc_back.sv
// Execution unit: scales voltage and temperature codes combinationally, runs
// the fan division step by step, and owns the result register. Depends on hrc_pkg.
module hrc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_queue_empty,
    input  hrc_pkg::t_work              i_work,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_reading_valid,
    output logic [hrc_pkg::VALUE_W-1:0] o_reading_value
);
    import hrc_pkg::*;

    localparam int unsigned QUO_KEEP_W = DIV_NUM_W - DIV_BITS_PER_STEP;

    logic                     r_busy;
    logic [DIV_STEP_W-1:0]    r_step;
    logic [COUNT_W-1:0]       r_count;
    logic [COUNT_W-1:0]       r_rem;
    logic [DIV_NUM_W-1:0]     r_num;
    logic [QUO_KEEP_W-1:0]    r_quo;
    logic                     r_out_valid;
    logic                     r_reading_valid;
    logic [VALUE_W-1:0]       r_reading_value;

    logic                     w_out_free;
    logic                     w_div_last;
    logic                     w_div_done;
    logic [VPROD_W-1:0]       w_volt_prod;
    logic [TPROD_W-1:0]       w_temp_prod;
    logic [VALUE_W-1:0]       w_direct_value;
    logic [COUNT_W:0]         w_rem_sh  [DIV_BITS_PER_STEP];
    logic [COUNT_W-1:0]       w_rem_out [DIV_BITS_PER_STEP];
    logic [DIV_BITS_PER_STEP-1:0] w_qbits;
    logic [DIV_NUM_W-1:0]     w_quotient;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = !i_queue_empty && !r_busy && w_out_free;
    assign w_div_last = (r_step == DIV_STEP_W'(DIV_STEPS - 1));
    assign w_div_done = r_busy && w_div_last && w_out_free;

    assign w_volt_prod = VPROD_W'(i_work.code) * VPROD_W'(i_work.scale);
    assign w_temp_prod = TPROD_W'(i_work.code) * MICRO_PER_UNIT;

    always_comb begin
        unique case (i_work.kind)
            KIND_VOLT: w_direct_value = VALUE_W'(w_volt_prod);
            KIND_TEMP: w_direct_value = VALUE_W'(w_temp_prod) + ZERO_C_MICROK;
            default:   w_direct_value = '0;
        endcase
    end

    // One divider step: shift in the next numerator bits, subtract where it fits
    always_comb begin
        for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
            if (j == 0) begin
                w_rem_sh[j] = {r_rem, r_num[DIV_NUM_W-1]};
            end else begin
                w_rem_sh[j] = {w_rem_out[j-1], r_num[DIV_NUM_W-1-j]};
            end
            if (w_rem_sh[j] >= {1'b0, r_count}) begin
                w_rem_out[j] = COUNT_W'(w_rem_sh[j] - {1'b0, r_count});
                w_qbits[DIV_BITS_PER_STEP-1-j] = 1'b1;
            end else begin
                w_rem_out[j] = w_rem_sh[j][COUNT_W-1:0];
                w_qbits[DIV_BITS_PER_STEP-1-j] = 1'b0;
            end
        end
    end

    assign w_quotient = {r_quo, w_qbits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (o_pop && i_work.kind == KIND_FAN) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_div_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && !w_div_last) begin
            r_step <= r_step + DIV_STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_work.kind == KIND_FAN) begin
            r_count <= i_work.count;
            r_rem   <= '0;
            r_num   <= FAN_NUMERATOR;
            r_quo   <= '0;
        end else if (r_busy && !w_div_last) begin
            r_rem <= w_rem_out[DIV_BITS_PER_STEP-1];
            r_num <= r_num << DIV_BITS_PER_STEP;
            r_quo <= QUO_KEEP_W'({r_quo, w_qbits});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((o_pop && i_work.kind != KIND_FAN) || w_div_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_reading_valid <= 1'b1;
            r_reading_value <= VALUE_W'(w_quotient);
        end else if (o_pop && i_work.kind != KIND_FAN) begin
            r_reading_valid <= (i_work.kind != KIND_ZERO);
            r_reading_value <= w_direct_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reading_valid = r_reading_valid;
    assign o_reading_value = r_reading_value;

endmodule

// File: hw/rtl/hwmon_reading_converter.sv
// Top level of the hardware-monitor reading converter.
// Depends on hrc_pkg, hrc_front, hrc_queue and hrc_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one raw reading per
//   request: op, raw_reading, user_scale, table_scale, aux_mask. The front
//   classifies it straight into a four-entry work queue; o_in_stall rises
//   only while that queue is full.
//   Output channel (o_out_valid / i_out_stall) returns one result per
//   request, in order: reading_valid and reading_value (0 when invalid).
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes temp_mode;
//   ready is always high. Write it only while no request is in flight.
// Path: voltage, temperature and invalid readings go from the queue to the
//   result register; fan readings pass through the divider at 6 quotient
//   bits per cycle, its last step waiting while the output is stalled.
// Throughput: one voltage or temperature reading per cycle while the output
//   is not stalled; the iterative divider holds the queue for a fan reading.
// Reset (i_rst_n low, synchronous) empties the queue, drops any division in
//   progress, clears o_out_valid and sets temp_mode to 0.
// A stall on the output holds the result register; the queue keeps filling
//   behind it until full, then the input is stalled.
module hwmon_reading_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hrc_pkg::AUX_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [hrc_pkg::RAW_W-1:0]     i_raw_reading,
    input  logic [hrc_pkg::SCALE_W-1:0]   i_user_scale,
    input  logic [hrc_pkg::SCALE_W-1:0]   i_table_scale,
    input  logic [hrc_pkg::AUX_W-1:0]     i_aux_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_reading_valid,
    output logic [hrc_pkg::VALUE_W-1:0]   o_reading_value
);
    import hrc_pkg::*;

    t_work       w_front_work;
    t_work       w_pop_work;
    t_queue_stat w_qstat;
    logic        w_push;
    logic        w_pop;
    logic        w_cfg_write;

    // Configuration is always taken at once
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // Stall the input only on a full queue
    assign o_in_stall = w_qstat.full;
    assign w_push     = i_in_valid && !o_in_stall;

    hrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (w_cfg_write),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_raw_reading (i_raw_reading),
        .i_user_scale  (i_user_scale),
        .i_table_scale (i_table_scale),
        .i_aux_mask    (i_aux_mask),
        .o_work        (w_front_work)
    );

    hrc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_front_work),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_work),
        .o_stat      (w_qstat)
    );

    // Advance work into the execution unit whenever it and the result register allow
    hrc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_queue_empty   (w_qstat.empty),
        .i_work          (w_pop_work),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reading_valid (o_reading_valid),
        .o_reading_value (o_reading_value)
    );

`ifndef SYNTHESIS
    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |-> (o_reading_value == '0))
        else $error("invalid reading carries a nonzero value");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reading_value <= VALUE_MAX))
        else $error("reading value above its largest legal value");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.empty |-> !w_pop)
        else $error("work popped from an empty queue");

    a_reset_clears_output: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result still offered right after reset");
`endif

endmodule

// File: tb/hrc_reading_check.sv
// Scoreboard for the hardware-monitor reading converter: watches the request,
// result and temp_mode channels, predicts each result and compares it.
// Depends on hrc_pkg for the op codes, widths and conversion constants.
module hrc_reading_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [hrc_pkg::AUX_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [hrc_pkg::RAW_W-1:0]     i_raw_reading,
    input  logic [hrc_pkg::SCALE_W-1:0]   i_user_scale,
    input  logic [hrc_pkg::SCALE_W-1:0]   i_table_scale,
    input  logic [hrc_pkg::AUX_W-1:0]     i_aux_mask,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_reading_valid,
    input  logic [hrc_pkg::VALUE_W-1:0]   i_reading_value,
    output logic [31:0]                   o_fail_count,
    output logic [31:0]                   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hrc_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } t_conversion;

    logic [AUX_W-1:0] sensor_mode = '0;
    t_conversion      pending_conversions[$];
    int unsigned      mismatches = 0;

    // Convert one raw reading to its validity flag and engineering value.
    function automatic t_conversion convert_reading(
        input logic [1:0]         op,
        input logic [RAW_W-1:0]   raw,
        input logic [SCALE_W-1:0] user_scale,
        input logic [SCALE_W-1:0] table_scale,
        input logic [AUX_W-1:0]   aux,
        input logic [AUX_W-1:0]   mode
    );
        t_conversion        res;
        logic [CODE_W-1:0]  code;
        logic [SCALE_W-1:0] scale;
        logic [CODE_W-1:0]  limit;
        int unsigned        wide;
        res   = '0;
        code  = raw[CODE_W-1:0];
        scale = (user_scale != '0) ? user_scale : table_scale;
        limit = ((mode & aux) != '0) ? TEMP_LIMIT_ALT : TEMP_LIMIT_STD;
        case (op)
            OP_VOLT: begin
                if (code != '0 && code != VOLT_BAD_HIGH) begin
                    wide      = 32'(code) * 32'(scale);
                    res.ok    = 1'b1;
                    res.value = wide[VALUE_W-1:0];
                end
            end
            OP_TEMP: begin
                if (code != '0 && code < limit) begin
                    wide      = 32'(code) * 32'(MICRO_PER_UNIT) + 32'(ZERO_C_MICROK);
                    res.ok    = 1'b1;
                    res.value = wide[VALUE_W-1:0];
                end
            end
            OP_FAN: begin
                // a zero count is flagged bad, so no divide by zero
                if (raw != '0 && raw < FAN_BAD_COUNT) begin
                    wide      = 32'(FAN_NUMERATOR) / 32'(raw);
                    res.ok    = 1'b1;
                    res.value = wide[VALUE_W-1:0];
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_conversion want;
        if (!i_rst_n) begin
            sensor_mode <= '0;
            pending_conversions.delete();
        end else begin
            // retire the oldest prediction before queueing a new one
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_conversions.size() == 0) begin
                    $error("result with no request outstanding: valid %0b value %0d",
                           i_reading_valid, i_reading_value);
                    mismatches++;
                end else begin
                    want = pending_conversions.pop_front();
                    if (i_reading_valid !== want.ok) begin
                        $error("reading_valid: expected %0b, got %0b",
                               want.ok, i_reading_valid);
                        mismatches++;
                    end
                    if (i_reading_value !== want.value) begin
                        $error("reading_value: expected %0d, got %0d",
                               want.value, i_reading_value);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                pending_conversions.push_back(convert_reading(i_op, i_raw_reading,
                    i_user_scale, i_table_scale, i_aux_mask, sensor_mode));
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1)
                sensor_mode <= i_cfg_data;
        end
        o_fail_count    <= mismatches;
        o_pending_count <= pending_conversions.size();
    end

endmodule

// File: tb/hwmon_reading_converter_tb.sv
// Top of the reading converter testbench: clock, reset, request stimulus,
// temp_mode writes, result back-pressure and the verdict.
// Depends on hrc_pkg, hwmon_reading_converter and hrc_reading_check.
module hwmon_reading_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrc_pkg::*;

    // Op code the converter does not use; it must come back invalid
    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         RANDOM_PER_PHASE = 147;
    // Fan requests run through the iterative divider; allow a margin past the last result
    localparam int         DRAIN_CYCLES     = 12;

    typedef struct packed {
        logic [1:0]         op;
        logic [RAW_W-1:0]   raw;
        logic [SCALE_W-1:0] user_scale;
        logic [SCALE_W-1:0] table_scale;
        logic [AUX_W-1:0]   aux;
    } t_reading;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_WAVE
    } t_stall_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic [AUX_W-1:0]   i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic [1:0]         i_op          = OP_VOLT;
    logic [RAW_W-1:0]   i_raw_reading = '0;
    logic [SCALE_W-1:0] i_user_scale  = '0;
    logic [SCALE_W-1:0] i_table_scale = '0;
    logic [AUX_W-1:0]   i_aux_mask    = '0;
    logic               i_out_stall   = 1'b0;

    logic               o_cfg_ready;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_reading_valid;
    logic [VALUE_W-1:0] o_reading_value;

    logic [31:0]        fail_count;
    logic [31:0]        pending_count;

    // Sender pacing: requests go out in bursts, with idle gaps between them
    int unsigned        burst_left = 0;
    logic               gapless    = 1'b0;

    // Receiver pacing: a stall pattern that is picked anew for each random stretch
    t_stall_mode        stall_mode = STALL_NONE;
    int unsigned        stall_left = 0;
    int unsigned        wave_count = 0;

    always #5 i_clk = ~i_clk;

    hwmon_reading_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_raw_reading   (i_raw_reading),
        .i_user_scale    (i_user_scale),
        .i_table_scale   (i_table_scale),
        .i_aux_mask      (i_aux_mask),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reading_valid (o_reading_valid),
        .o_reading_value (o_reading_value)
    );

    hrc_reading_check u_reading_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_raw_reading   (i_raw_reading),
        .i_user_scale    (i_user_scale),
        .i_table_scale   (i_table_scale),
        .i_aux_mask      (i_aux_mask),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_reading_valid (o_reading_valid),
        .i_reading_value (o_reading_value),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Back-pressure on the result side. Each stretch picks one of: no stall
    // at all, a coin toss per cycle, mostly stalled, or a square wave from a
    // counter bit, so that stalls land on every phase of the fan divider.
    always @(posedge i_clk) begin
        wave_count <= wave_count + 1;
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(8, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= wave_count[2];
        endcase
    end

    function automatic t_reading make_reading(
        input logic [1:0]         op,
        input logic [RAW_W-1:0]   raw,
        input logic [SCALE_W-1:0] user_scale,
        input logic [SCALE_W-1:0] table_scale,
        input logic [AUX_W-1:0]   aux
    );
        t_reading r;
        r.op          = op;
        r.raw         = raw;
        r.user_scale  = user_scale;
        r.table_scale = table_scale;
        r.aux         = aux;
        return r;
    endfunction

    // Build one random request, weighted towards the edges of each mode:
    // bad voltage codes, codes around both temperature limits, fan counts
    // near zero and near the bad-count threshold, zero and full-scale
    // resistor factors, and aux masks that hit or miss temp_mode.
    function automatic t_reading random_reading();
        t_reading    r;
        int unsigned pick;
        int unsigned sel;
        pick          = $urandom_range(0, 99);
        r.raw         = RAW_W'($urandom());
        r.user_scale  = SCALE_W'($urandom());
        r.table_scale = SCALE_W'($urandom());
        r.aux         = AUX_W'($urandom());
        if (pick < 34)
            r.op = OP_VOLT;
        else if (pick < 67)
            r.op = OP_TEMP;
        else if (pick < 94)
            r.op = OP_FAN;
        else
            r.op = OP_UNUSED;

        sel = $urandom_range(0, 9);
        case (r.op)
            OP_VOLT: begin
                case (sel)
                    0: r.raw[CODE_W-1:0] = 8'd0;
                    1: r.raw[CODE_W-1:0] = VOLT_BAD_HIGH;
                    2: r.raw[CODE_W-1:0] = 8'd1;
                    3: r.raw[CODE_W-1:0] = 8'd254;
                    default: ;
                endcase
            end
            OP_TEMP: begin
                case (sel)
                    0: r.raw[CODE_W-1:0] = 8'd0;
                    1, 2: r.raw[CODE_W-1:0] = CODE_W'($urandom_range(105, 130));
                    3, 4, 5: r.raw[CODE_W-1:0] = CODE_W'($urandom_range(1, 127));
                    default: ;
                endcase
            end
            OP_FAN: begin
                case (sel)
                    0: r.raw = '0;
                    1: r.raw = RAW_W'($urandom_range(4090, 4100));
                    2: r.raw = RAW_W'($urandom_range(1, 16));
                    3: ;
                    default: r.raw = RAW_W'($urandom_range(1, 4094));
                endcase
            end
            default: ;
        endcase

        sel = $urandom_range(0, 7);
        if (sel == 0)
            r.user_scale = '0;
        else if (sel == 1)
            r.user_scale = '1;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            r.table_scale = '0;
        else if (sel == 1)
            r.table_scale = '1;

        sel = $urandom_range(0, 7);
        case (sel)
            0: r.aux = '0;
            1: r.aux = AUX_W'(1) << $urandom_range(0, AUX_W-1);
            2: r.aux = '1;
            default: ;
        endcase
        return r;
    endfunction

    // Present one request, hold it until accepted, then pace the next one:
    // advance through the burst, or drop valid for a random gap and start
    // a fresh burst. Valid is only lowered when a gap really follows.
    task automatic send_reading(input t_reading r);
        int unsigned gap;
        i_in_valid    <= 1'b1;
        i_op          <= r.op;
        i_raw_reading <= r.raw;
        i_user_scale  <= r.user_scale;
        i_table_scale <= r.table_scale;
        i_aux_mask    <= r.aux;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (gapless || burst_left > 0) begin
            if (burst_left > 0)
                burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Drop valid and wait until every predicted result has come back. The
    // first edge is always taken so that a request accepted at this very
    // edge is already counted as pending.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Write temp_mode only once the converter has nothing in flight.
    task automatic write_temp_mode(input logic [AUX_W-1:0] mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [AUX_W-1:0] phase_modes[7];
        phase_modes = '{8'h00, 8'hff, 8'h01, 8'h80,
                        AUX_W'($urandom()), AUX_W'($urandom()), AUX_W'($urandom())};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset value of temp_mode.
        // Voltage: both bad codes, smallest and largest good codes with the
        // largest factors, factor taken from the table, both factors zero,
        // and an upper byte that must be ignored.
        send_reading(make_reading(OP_VOLT, 16'h0000, 18'd5, 18'd7, 8'h00));
        send_reading(make_reading(OP_VOLT, 16'h00ff, 18'd5, 18'd7, 8'h00));
        send_reading(make_reading(OP_VOLT, 16'h0001, '1, 18'd3, 8'h00));
        send_reading(make_reading(OP_VOLT, 16'h00fe, 18'd0, '1, 8'h00));
        send_reading(make_reading(OP_VOLT, 16'h0080, 18'd0, 18'd0, 8'hff));
        send_reading(make_reading(OP_VOLT, 16'hff01, 18'd0, 18'd3, 8'h00));
        // Temperature with temp_mode clear: the standard limit applies
        // whatever the aux mask holds.
        send_reading(make_reading(OP_TEMP, 16'h0000, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_TEMP, 16'h0001, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_TEMP, 16'h007f, 18'd0, 18'd0, 8'hff));
        send_reading(make_reading(OP_TEMP, 16'h0080, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_TEMP, 16'hff7f, '1, '1, 8'h00));
        // Fan: zero count (no division), the largest quotient, both sides
        // of the bad-count threshold, the full 16-bit count, a mid value.
        send_reading(make_reading(OP_FAN, 16'd0, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_FAN, 16'd1, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_FAN, 16'd4094, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_FAN, 16'd4095, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_FAN, 16'hffff, '1, '1, 8'hff));
        send_reading(make_reading(OP_FAN, 16'd3000, 18'd0, 18'd0, 8'h00));
        // Unused op code: always invalid
        send_reading(make_reading(OP_UNUSED, 16'h1234, 18'd9, 18'd9, 8'hff));

        // With every mode bit set the alternate limit applies whenever the
        // aux mask is nonzero.
        write_temp_mode(8'hff);
        send_reading(make_reading(OP_TEMP, 16'h006e, 18'd0, 18'd0, 8'h01));
        send_reading(make_reading(OP_TEMP, 16'h006f, 18'd0, 18'd0, 8'h80));
        send_reading(make_reading(OP_TEMP, 16'h006f, 18'd0, 18'd0, 8'h00));
        send_reading(make_reading(OP_TEMP, 16'h007f, 18'd0, 18'd0, 8'hff));

        // Random phases, one temp_mode setting each. The third phase runs
        // with no gaps at all so the queue fills behind fan divisions.
        for (int p = 0; p < 7; p++) begin
            write_temp_mode(phase_modes[p]);
            gapless = (p == 2);
            repeat (RANDOM_PER_PHASE) send_reading(random_reading());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard: far longer than the slowest correct run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
